>>> sv/afrs_pkg.sv
// Shared types and constants for the accelerometer register-map slave.
// Holds the beat structs, operation codes and register addresses.
// No dependencies.
package afrs_pkg;

  localparam int SAMPLE_BYTES = 6;
  localparam int SAMPLE_W     = 8 * SAMPLE_BYTES;

  // Operation codes carried in the op field of an input beat.
  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_ADDR  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;
  localparam logic [2:0] OP_BERR  = 3'd5;
  localparam logic [2:0] OP_CLEAR = 3'd6;

  // Register map addresses.
  localparam logic [7:0] ADDR_F_STATUS  = 8'h00;
  localparam logic [7:0] ADDR_OUT_FIRST = 8'h01;
  localparam logic [7:0] ADDR_F_SETUP   = 8'h09;
  localparam logic [7:0] ADDR_WHO_AM_I  = 8'h0D;
  localparam logic [7:0] ADDR_DATA_CFG  = 8'h0E;
  localparam logic [7:0] ADDR_CTRL1     = 8'h2A;
  localparam logic [7:0] ADDR_CTRL2     = 8'h2B;
  localparam logic [7:0] ADDR_CTRL3     = 8'h2C;
  localparam logic [7:0] ADDR_CTRL4     = 8'h2D;
  localparam logic [7:0] ADDR_CTRL5     = 8'h2E;

  localparam logic [7:0] ID_VALUE       = 8'h1A;
  localparam logic [7:0] CTRL3_RESET    = 8'h02;
  localparam logic [7:0] BIT_ACTIVE     = 8'h01;
  localparam logic [7:0] MASK_MODE      = 8'hC0;
  localparam logic [7:0] MASK_WMRK      = 8'h3F;
  localparam logic [7:0] BIT_INT_FIFO   = 8'h40;
  localparam logic [7:0] BIT_WMRK_FLAG  = 8'h40;
  localparam logic [7:0] BIT_OVF        = 8'h80;

  typedef struct packed {
    logic [2:0]         op;
    logic               is_read;
    logic [7:0]         data_byte;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
    logic [5:0] fifo_level;
    logic       sample_taken;
  } out_t;

endpackage

>>> sv/accel_fifo_register_slave_core.sv
// Accelerometer bus-slave register map with a sample FIFO in afrs_fifo_mem; uses afrs_pkg.
// An accepted beat is held in the input register while the execute state runs; its result beat
// is registered when that state completes. A new beat is taken only after the last one has
// executed. The accept step reads the FIFO head entry from the sample memory; the execute step
// uses it and writes state back, and holds while the output register is full and stalled.
// Reset (rst, synchronous, active high) clears all control state; the sample memory is not cleared.
module accel_fifo_register_slave_core import afrs_pkg::*; #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);
  localparam logic [5:0]    DEPTH_W  = 6'(FIFO_DEPTH);

  // Two-state sequencer: wait for a beat, then execute it.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic [0:0] state;
  in_t        item;

  // Architectural state.
  logic [7:0]          ctrl_one, data_cfg, fifo_setup, ctrl_two, ctrl_three, ctrl_four,
                       ctrl_five;
  logic [7:0]          reg_pointer, current_reg;
  logic                address_seen, burst_active, running, irq_line;
  logic [AW-1:0]       fifo_head, fifo_tail;
  logic [5:0]          fifo_count;
  logic [SAMPLE_W-1:0] staged_sample;
  logic [2:0]          byte_index;

  logic [7:0]          ctrl_one_next, data_cfg_next, fifo_setup_next, ctrl_two_next;
  logic [7:0]          ctrl_three_next, ctrl_four_next, ctrl_five_next;
  logic [7:0]          reg_pointer_next, current_reg_next;
  logic                address_seen_next, burst_active_next, running_next, irq_line_next;
  logic [AW-1:0]       fifo_head_next, fifo_tail_next;
  logic [5:0]          fifo_count_next;
  logic [SAMPLE_W-1:0] staged_sample_next;
  logic [2:0]          byte_index_next;

  logic                accept, exec_go, push_ok;
  logic [SAMPLE_W-1:0] head_sample;
  logic [7:0]          reg_rdata, rdata;
  logic [SAMPLE_W-1:0] sel_sample;
  logic [2:0]          sel_index;

  // A beat is taken only while the sequencer waits; reset holds the input side off.
  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // The execute cycle completes once the output register can take the result.
  assign exec_go  = (state == S_EXEC) && (!out_valid || !out_stall);
  assign push_ok  = (item.op == OP_PUSH) && running && (fifo_count < DEPTH_W);

  // The head entry is read on every accept, so a pop in the execute cycle has it ready.
  // The entry read is only used when the FIFO holds at least one written sample.
  afrs_fifo_mem #(.DEPTH(FIFO_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (exec_go && push_ok),
    .wr_addr (fifo_tail),
    .wr_data ({item.sample_x, item.sample_y, item.sample_z}),
    .rd_en   (accept),
    .rd_addr (fifo_head),
    .rd_data (head_sample)
  );

  function automatic logic irq_eval(input logic [7:0] c1, input logic [7:0] fs,
                                    input logic [7:0] c4, input logic [5:0] cnt);
    irq_eval = ((c1 & BIT_ACTIVE) != 8'h00) && ((fs & MASK_MODE) != 8'h00) &&
               ((c4 & BIT_INT_FIFO) != 8'h00) && ({2'b00, cnt} > (fs & MASK_WMRK));
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // Register map read of the current register.
  always_comb begin
    case (current_reg)
      ADDR_F_STATUS: begin
        reg_rdata = {2'b00, fifo_count};
        if ({2'b00, fifo_count} > (fifo_setup & MASK_WMRK)) begin
          reg_rdata = reg_rdata | BIT_WMRK_FLAG;
        end
        if (fifo_count >= DEPTH_W) begin
          reg_rdata = reg_rdata | BIT_OVF;
        end
      end
      ADDR_F_SETUP:  reg_rdata = fifo_setup;
      ADDR_WHO_AM_I: reg_rdata = ID_VALUE;
      ADDR_DATA_CFG: reg_rdata = data_cfg;
      ADDR_CTRL1:    reg_rdata = ctrl_one;
      ADDR_CTRL2:    reg_rdata = ctrl_two;
      ADDR_CTRL3:    reg_rdata = ctrl_three;
      ADDR_CTRL4:    reg_rdata = ctrl_four;
      ADDR_CTRL5:    reg_rdata = ctrl_five;
      default:       reg_rdata = 8'h00;
    endcase
  end

  // Execute step: computes every next value and the returned byte.
  always_comb begin
    ctrl_one_next      = ctrl_one;
    data_cfg_next      = data_cfg;
    fifo_setup_next    = fifo_setup;
    ctrl_two_next      = ctrl_two;
    ctrl_three_next    = ctrl_three;
    ctrl_four_next     = ctrl_four;
    ctrl_five_next     = ctrl_five;
    reg_pointer_next   = reg_pointer;
    current_reg_next   = current_reg;
    address_seen_next  = address_seen;
    burst_active_next  = burst_active;
    running_next       = running;
    irq_line_next      = irq_line;
    fifo_head_next     = fifo_head;
    fifo_tail_next     = fifo_tail;
    fifo_count_next    = fifo_count;
    staged_sample_next = staged_sample;
    byte_index_next    = byte_index;
    rdata              = 8'h00;
    sel_sample         = staged_sample;
    sel_index          = byte_index;

    if (exec_go) begin
      case (item.op)
        OP_PUSH: begin
          if (push_ok) begin
            fifo_tail_next  = ptr_inc(fifo_tail);
            fifo_count_next = fifo_count + 6'd1;
            irq_line_next   = irq_eval(ctrl_one, fifo_setup, ctrl_four, fifo_count_next);
          end
        end
        OP_ADDR: begin
          address_seen_next = 1'b0;
          burst_active_next = 1'b0;
          byte_index_next   = 3'd0;
          if (item.is_read) begin
            current_reg_next = reg_pointer;
            // A read that starts at the first output register opens a burst if a
            // sample is there to pop.
            if ((reg_pointer == ADDR_OUT_FIRST) && (fifo_count != 6'd0)) begin
              staged_sample_next = head_sample;
              fifo_head_next     = ptr_inc(fifo_head);
              fifo_count_next    = fifo_count - 6'd1;
              burst_active_next  = 1'b1;
            end
          end
        end
        OP_WRITE: begin
          if (!address_seen) begin
            reg_pointer_next = item.data_byte;
            current_reg_next = item.data_byte;
          end else begin
            case (current_reg)
              ADDR_CTRL1: begin
                ctrl_one_next = item.data_byte;
                running_next  = (item.data_byte & BIT_ACTIVE) != 8'h00;
                irq_line_next = irq_eval(item.data_byte, fifo_setup, ctrl_four, fifo_count);
              end
              ADDR_DATA_CFG: data_cfg_next   = item.data_byte;
              ADDR_F_SETUP:  fifo_setup_next = item.data_byte;
              ADDR_CTRL2:    ctrl_two_next   = item.data_byte;
              ADDR_CTRL3:    ctrl_three_next = item.data_byte;
              ADDR_CTRL4:    ctrl_four_next  = item.data_byte;
              ADDR_CTRL5:    ctrl_five_next  = item.data_byte;
              default:       ;
            endcase
            current_reg_next = current_reg + 8'd1;
            reg_pointer_next = current_reg + 8'd1;
          end
          address_seen_next = 1'b1;
        end
        OP_READ: begin
          if (burst_active) begin
            // After six bytes the next sample is popped; a dry FIFO ends the burst.
            if (byte_index >= 3'(SAMPLE_BYTES)) begin
              if (fifo_count != 6'd0) begin
                staged_sample_next = head_sample;
                fifo_head_next     = ptr_inc(fifo_head);
                fifo_count_next    = fifo_count - 6'd1;
                sel_sample         = head_sample;
                sel_index          = 3'd0;
              end else begin
                burst_active_next = 1'b0;
              end
            end
            if (burst_active_next) begin
              // Bytes go out big-endian: X MSB first, Z LSB last.
              case (sel_index)
                3'd0:    rdata = sel_sample[47:40];
                3'd1:    rdata = sel_sample[39:32];
                3'd2:    rdata = sel_sample[31:24];
                3'd3:    rdata = sel_sample[23:16];
                3'd4:    rdata = sel_sample[15:8];
                3'd5:    rdata = sel_sample[7:0];
                default: rdata = 8'h00;
              endcase
              byte_index_next = sel_index + 3'd1;
            end
          end else begin
            rdata = reg_rdata;
          end
          current_reg_next = current_reg + 8'd1;
          reg_pointer_next = current_reg + 8'd1;
        end
        OP_STOP: begin
          address_seen_next = 1'b0;
          burst_active_next = 1'b0;
          byte_index_next   = 3'd0;
          irq_line_next     = irq_eval(ctrl_one, fifo_setup, ctrl_four, fifo_count);
        end
        OP_BERR: begin
          address_seen_next = 1'b0;
          reg_pointer_next  = ADDR_F_STATUS;
          current_reg_next  = ADDR_F_STATUS;
          burst_active_next = 1'b0;
          byte_index_next   = 3'd0;
          irq_line_next     = irq_eval(ctrl_one, fifo_setup, ctrl_four, fifo_count);
        end
        OP_CLEAR: begin
          // The staged burst sample is left in place.
          fifo_head_next  = '0;
          fifo_tail_next  = '0;
          fifo_count_next = 6'd0;
          irq_line_next   = irq_eval(ctrl_one, fifo_setup, ctrl_four, 6'd0);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ctrl_one      <= 8'h00;
      data_cfg      <= 8'h00;
      fifo_setup    <= 8'h00;
      ctrl_two      <= 8'h00;
      ctrl_three    <= CTRL3_RESET;
      ctrl_four     <= 8'h00;
      ctrl_five     <= 8'h00;
      reg_pointer   <= ADDR_F_STATUS;
      current_reg   <= ADDR_F_STATUS;
      address_seen  <= 1'b0;
      burst_active  <= 1'b0;
      running       <= 1'b0;
      irq_line      <= 1'b0;
      fifo_head     <= '0;
      fifo_tail     <= '0;
      fifo_count    <= 6'd0;
      staged_sample <= '0;
      byte_index    <= 3'd0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        state <= S_EXEC;
      end else if (exec_go) begin
        state <= S_IDLE;
      end
      ctrl_one      <= ctrl_one_next;
      data_cfg      <= data_cfg_next;
      fifo_setup    <= fifo_setup_next;
      ctrl_two      <= ctrl_two_next;
      ctrl_three    <= ctrl_three_next;
      ctrl_four     <= ctrl_four_next;
      ctrl_five     <= ctrl_five_next;
      reg_pointer   <= reg_pointer_next;
      current_reg   <= current_reg_next;
      address_seen  <= address_seen_next;
      burst_active  <= burst_active_next;
      running       <= running_next;
      irq_line      <= irq_line_next;
      fifo_head     <= fifo_head_next;
      fifo_tail     <= fifo_tail_next;
      fifo_count    <= fifo_count_next;
      staged_sample <= staged_sample_next;
      byte_index    <= byte_index_next;
      if (exec_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input beat and result beat payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (exec_go) begin
      out_data.read_data    <= rdata;
      out_data.irq_out      <= irq_line_next;
      out_data.fifo_level   <= fifo_count_next;
      out_data.sample_taken <= push_ok;
    end
  end

  // The FIFO never holds more samples than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= DEPTH_W)
    else $error("FIFO count exceeds depth");

  // A taken push grows the count by exactly one.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (exec_go && push_ok) |=> (fifo_count == $past(fifo_count) + 6'd1))
    else $error("taken push did not advance the count");

  // The interrupt can only be high while the device is active.
  a_irq_active: assert property (@(posedge clk) disable iff (rst)
    irq_line |-> ((ctrl_one & BIT_ACTIVE) != 8'h00))
    else $error("interrupt high while device inactive");

  // Inside a burst the byte position never passes the end of a sample.
  a_burst_index: assert property (@(posedge clk) disable iff (rst)
    burst_active |-> (byte_index <= 3'(SAMPLE_BYTES)))
    else $error("burst byte index out of range");

endmodule

>>> sv/afrs_fifo_mem.sv
// Sample store of the FIFO: one write port and one read port, read data registered.
// Uses afrs_pkg for the sample width.
module afrs_fifo_mem import afrs_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [SAMPLE_W-1:0] wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
